// File: design/scsf_pkg.sv
// ----------------------------------------------------------------------------
// scsf_pkg: shared types and constants of the strip cluster stub finder
// Sizes, register indexes and reset values, beat structs, the event
// descriptor that travels from the front to the back, and helpers.
// ----------------------------------------------------------------------------
package scsf_pkg;

	// sizes
	localparam int NUM_STRIPS   = 32;
	localparam int MAX_CLUSTERS = 16;
	localparam int EVQ_DEPTH    = 2;

	localparam int IDX_W      = $clog2(NUM_STRIPS);
	localparam int SPOS_W     = $clog2(NUM_STRIPS + 1);
	localparam int SLOT_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CNT_W      = $clog2(MAX_CLUSTERS + 1);
	localparam int BANK_W     = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
	localparam int EVQC_W     = $clog2(EVQ_DEPTH + 1);
	localparam int POS_DEPTH  = EVQ_DEPTH * MAX_CLUSTERS;
	localparam int POS_ADDR_W = (POS_DEPTH > 1) ? $clog2(POS_DEPTH) : 1;

	// counter and field widths
	localparam int RUN_W     = 6;
	localparam int RUN_MAX   = 63;
	localparam int TALLY_W   = 5;
	localparam int COUNT_MAX = 31;
	localparam int SUM_W     = 6;
	localparam int SUMX_W    = SUM_W + 1;
	localparam int SUM_MAX   = 63;
	localparam int NUM_TALLY = 5;
	localparam int THR_W     = 16;
	localparam int MAXW_W    = 6;
	localparam int WIN_W     = 5;
	localparam int POS_EXT_W = (IDX_W > RUN_W) ? IDX_W : RUN_W;
	localparam int CMP_W     = (IDX_W > WIN_W) ? IDX_W : WIN_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEPTED_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW       = 2'd2;

	localparam logic [THR_W-1:0]  HIT_THRESHOLD_RST      = 16'd144;
	localparam logic [MAXW_W-1:0] MAX_ACCEPTED_WIDTH_RST = 6'd3;
	localparam logic [WIN_W-1:0]  MATCH_WINDOW_RST       = 5'd5;

	// input beat: one strip of each sensor
	typedef struct packed {
		logic [15:0] energy_a;
		logic [15:0] energy_b;
		logic        last_strip;
	} strip_t;

	// output beat: per-sensor cluster summary
	typedef struct packed {
		logic         sensor_select;
		logic [4:0]   width1_count;
		logic [4:0]   width2_count;
		logic [4:0]   width3_count;
		logic [4:0]   width4_count;
		logic [4:0]   width5_count;
		logic [4:0]   total_clusters;
		logic [5:0]   total_width_sum;
		logic [4:0]   accepted_clusters;
		logic [5:0]   accepted_width_sum;
		logic         stub_found;
		logic         event_done;
	} result_t;

	// per-sensor counters of one event
	typedef struct packed {
		logic [NUM_TALLY-1:0][TALLY_W-1:0] tally;
		logic [TALLY_W-1:0]                cluster_total;
		logic [SUM_W-1:0]                  width_total;
		logic [TALLY_W-1:0]                accepted_total;
		logic [SUM_W-1:0]                  accepted_widths;
		logic [CNT_W-1:0]                  stored;
	} lane_sum_t;

	// finished event handed from front to back
	typedef struct packed {
		lane_sum_t a;
		lane_sum_t b;
	} event_desc_t;

	// event queue status
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [BANK_W-1:0] wr_slot;
		logic [BANK_W-1:0] rd_slot;
	} evq_status_t;

	// position store write
	typedef struct packed {
		logic                  en;
		logic [POS_ADDR_W-1:0] addr;
		logic [IDX_W-1:0]      data;
	} pos_wr_t;

	// back part sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_SEND_A,
		BK_SEND_B
	} back_state_t;

	// position store address of one entry in one queue slot's bank
	function automatic logic [POS_ADDR_W-1:0] pos_addr(
		input logic [BANK_W-1:0] bank,
		input logic [SLOT_W-1:0] slot
	);
		pos_addr = POS_ADDR_W'(bank) * POS_ADDR_W'(MAX_CLUSTERS) + POS_ADDR_W'(slot);
	endfunction

	// result beat from one sensor's counters
	function automatic result_t make_result(
		input lane_sum_t s,
		input logic      sel,
		input logic      stub
	);
		result_t r;
		r.sensor_select      = sel;
		r.width1_count       = s.tally[0];
		r.width2_count       = s.tally[1];
		r.width3_count       = s.tally[2];
		r.width4_count       = s.tally[3];
		r.width5_count       = s.tally[4];
		r.total_clusters     = s.cluster_total;
		r.total_width_sum    = s.width_total;
		r.accepted_clusters  = s.accepted_total;
		r.accepted_width_sum = s.accepted_widths;
		r.stub_found         = stub;
		r.event_done         = sel;
		return r;
	endfunction

endpackage

// File: design/scsf_ram.sv
// ----------------------------------------------------------------------------
// scsf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: design/scsf_front.sv
// ----------------------------------------------------------------------------
// scsf_front: strip intake and clustering
// Takes one strip beat per cycle unless stalled, tracks hit runs per sensor,
// counts clusters, writes accepted positions and pushes a finished event.
// ----------------------------------------------------------------------------
module scsf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          strip_valid,
	output logic                          strip_stall,
	input  scsf_pkg::strip_t              strip,
	input  logic [scsf_pkg::THR_W-1:0]    hit_threshold,
	input  logic [scsf_pkg::MAXW_W-1:0]   max_accepted_width,
	input  scsf_pkg::evq_status_t         evq_status,
	output logic                          push,
	output scsf_pkg::event_desc_t         push_desc,
	output scsf_pkg::pos_wr_t             pos_wr_a,
	output scsf_pkg::pos_wr_t             pos_wr_b
);
	import scsf_pkg::*;

	typedef struct packed {
		logic              in_run;
		logic [RUN_W-1:0]  run_len;
		lane_sum_t         sum;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_pos;
	} lane_upd_t;

	// one strip on one sensor: extend, close or open a run
	function automatic lane_upd_t lane_update(
		input logic              in_run,
		input logic [RUN_W-1:0]  run_len,
		input lane_sum_t         sum,
		input logic              hit,
		input logic              idx_ok,
		input logic [IDX_W-1:0]  idx,
		input logic              last,
		input logic [MAXW_W-1:0] max_w
	);
		lane_upd_t              u;
		logic                   open_now;
		logic                   close;
		logic [RUN_W-1:0]       w;
		logic [IDX_W-1:0]       end_idx;
		logic [POS_EXT_W-1:0]   end_ext;
		logic [POS_EXT_W-1:0]   half_ext;
		logic [SUMX_W-1:0]      wsum;
		logic [SUMX_W-1:0]      asum;
		u.sum    = sum;
		u.wr_en  = 1'b0;
		u.wr_pos = '0;
		w        = run_len;
		open_now = in_run;
		if (idx_ok && hit) begin
			open_now = 1'b1;
			if (!in_run) begin
				w = RUN_W'(1);
			end else if (run_len != RUN_W'(RUN_MAX)) begin
				w = run_len + 1'b1;
			end
		end else if (idx_ok) begin
			open_now = 1'b0;
		end
		close = (idx_ok && !hit && in_run) || (last && open_now);
		// a miss ends the run on the previous strip
		if (idx_ok && !hit) begin
			end_idx = idx - 1'b1;
		end else if (idx_ok) begin
			end_idx = idx;
		end else begin
			end_idx = IDX_W'(NUM_STRIPS - 1);
		end
		end_ext  = POS_EXT_W'(end_idx);
		half_ext = POS_EXT_W'(w >> 1);
		wsum     = SUMX_W'(sum.width_total) + SUMX_W'(w);
		asum     = SUMX_W'(sum.accepted_widths) + SUMX_W'(w);
		if (close) begin
			for (int k = 0; k < NUM_TALLY; k++) begin
				if (w == RUN_W'(k + 1) && sum.tally[k] != TALLY_W'(COUNT_MAX)) begin
					u.sum.tally[k] = sum.tally[k] + 1'b1;
				end
			end
			if (sum.cluster_total != TALLY_W'(COUNT_MAX)) begin
				u.sum.cluster_total = sum.cluster_total + 1'b1;
			end
			u.sum.width_total = (wsum > SUMX_W'(SUM_MAX)) ? SUM_W'(SUM_MAX)
				: wsum[SUM_W-1:0];
			if (w <= max_w) begin
				if (sum.accepted_total != TALLY_W'(COUNT_MAX)) begin
					u.sum.accepted_total = sum.accepted_total + 1'b1;
				end
				u.sum.accepted_widths = (asum > SUMX_W'(SUM_MAX)) ? SUM_W'(SUM_MAX)
					: asum[SUM_W-1:0];
				if (sum.stored < CNT_W'(MAX_CLUSTERS)) begin
					u.wr_en     = 1'b1;
					u.wr_pos    = (end_ext >= half_ext) ? IDX_W'(end_ext - half_ext) : '0;
					u.sum.stored = sum.stored + 1'b1;
				end
			end
			open_now = 1'b0;
			w        = '0;
		end
		u.in_run  = open_now;
		u.run_len = w;
		return u;
	endfunction

	logic [SPOS_W-1:0] spos_q;
	logic              in_run_a_q;
	logic              in_run_b_q;
	logic [RUN_W-1:0]  run_len_a_q;
	logic [RUN_W-1:0]  run_len_b_q;
	lane_sum_t         sum_a_q;
	lane_sum_t         sum_b_q;

	logic              accept;
	logic              idx_ok;
	logic [IDX_W-1:0]  idx;
	lane_upd_t         upd_a;
	lane_upd_t         upd_b;

	// intake handshake: a free queue slot means a free position bank
	assign strip_stall = evq_status.full;
	assign accept      = strip_valid && !strip_stall;
	assign idx_ok      = spos_q < SPOS_W'(NUM_STRIPS);
	assign idx         = spos_q[IDX_W-1:0];

	// cluster logic per sensor
	assign upd_a = lane_update(in_run_a_q, run_len_a_q, sum_a_q,
		strip.energy_a >= hit_threshold, idx_ok, idx, strip.last_strip,
		max_accepted_width);
	assign upd_b = lane_update(in_run_b_q, run_len_b_q, sum_b_q,
		strip.energy_b >= hit_threshold, idx_ok, idx, strip.last_strip,
		max_accepted_width);

	// finished event to the queue
	assign push        = accept && strip.last_strip;
	assign push_desc.a = upd_a.sum;
	assign push_desc.b = upd_b.sum;

	// accepted positions into the bank of the slot being filled
	assign pos_wr_a.en   = accept && upd_a.wr_en;
	assign pos_wr_a.addr = pos_addr(evq_status.wr_slot, sum_a_q.stored[SLOT_W-1:0]);
	assign pos_wr_a.data = upd_a.wr_pos;
	assign pos_wr_b.en   = accept && upd_b.wr_en;
	assign pos_wr_b.addr = pos_addr(evq_status.wr_slot, sum_b_q.stored[SLOT_W-1:0]);
	assign pos_wr_b.data = upd_b.wr_pos;

	// strip counter and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spos_q      <= '0;
			in_run_a_q  <= 1'b0;
			in_run_b_q  <= 1'b0;
			run_len_a_q <= '0;
			run_len_b_q <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
		end else if (accept) begin
			if (strip.last_strip) begin
				spos_q      <= '0;
				in_run_a_q  <= 1'b0;
				in_run_b_q  <= 1'b0;
				run_len_a_q <= '0;
				run_len_b_q <= '0;
				sum_a_q     <= '0;
				sum_b_q     <= '0;
			end else begin
				if (idx_ok) begin
					spos_q <= spos_q + 1'b1;
				end
				in_run_a_q  <= upd_a.in_run;
				in_run_b_q  <= upd_b.in_run;
				run_len_a_q <= upd_a.run_len;
				run_len_b_q <= upd_b.run_len;
				sum_a_q     <= upd_a.sum;
				sum_b_q     <= upd_b.sum;
			end
		end
	end

endmodule

// File: design/scsf_evq.sv
// ----------------------------------------------------------------------------
// scsf_evq: event queue between front and back
// Holds finished event descriptors; the slot index also names the
// position bank that belongs to the event.
// ----------------------------------------------------------------------------
module scsf_evq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  scsf_pkg::event_desc_t  push_desc,
	input  logic                   pop,
	output scsf_pkg::evq_status_t  status,
	output scsf_pkg::event_desc_t  head
);
	import scsf_pkg::*;

	event_desc_t       slot_q [EVQ_DEPTH];
	logic [BANK_W-1:0] wr_ptr_q;
	logic [BANK_W-1:0] rd_ptr_q;
	logic [EVQC_W-1:0] count_q;

	assign status.full    = count_q == EVQC_W'(EVQ_DEPTH);
	assign status.empty   = count_q == '0;
	assign status.wr_slot = wr_ptr_q;
	assign status.rd_slot = rd_ptr_q;
	assign head           = slot_q[rd_ptr_q];

	// descriptor storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == BANK_W'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == BANK_W'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/scsf_back.sv
// ----------------------------------------------------------------------------
// scsf_back: stub search and result output
// Walks stored A/B position pairs of the head event, one pair per cycle, up
// to a match, then sends the A and B result beats through an output register.
// ----------------------------------------------------------------------------
module scsf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [scsf_pkg::WIN_W-1:0]        match_window,
	input  scsf_pkg::evq_status_t             evq_status,
	input  scsf_pkg::event_desc_t             head,
	output logic                              pop,
	output logic [scsf_pkg::POS_ADDR_W-1:0]   rd_addr_a,
	output logic [scsf_pkg::POS_ADDR_W-1:0]   rd_addr_b,
	input  logic [scsf_pkg::IDX_W-1:0]        rd_data_a,
	input  logic [scsf_pkg::IDX_W-1:0]        rd_data_b,
	output logic                              result_valid,
	input  logic                              result_stall,
	output scsf_pkg::result_t                 result
);
	import scsf_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SLOT_W-1:0] i_q;
	logic [SLOT_W-1:0] j_q;
	logic              done_q;
	logic              cmp_s1;
	logic              stub_q;
	logic              result_valid_q;
	result_t           result_q;

	logic              start;
	logic              step;
	logic              send_a;
	logic              send_b;
	logic              slot_free;
	logic              found;
	logic [IDX_W-1:0]  diff;

	// pair read addresses in the head event's bank
	assign rd_addr_a = pos_addr(evq_status.rd_slot, i_q);
	assign rd_addr_b = pos_addr(evq_status.rd_slot, j_q);

	// distance of the pair read last cycle
	assign diff  = (rd_data_a >= rd_data_b) ? rd_data_a - rd_data_b : rd_data_b - rd_data_a;
	assign found = cmp_s1 && (CMP_W'(diff) <= CMP_W'(match_window));

	assign slot_free    = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		step    = 1'b0;
		send_a  = 1'b0;
		send_b  = 1'b0;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!evq_status.empty) begin
					start = 1'b1;
					if (head.a.stored == '0 || head.b.stored == '0) begin
						state_d = BK_SEND_A;
					end else begin
						state_d = BK_SEARCH;
					end
				end
			end
			BK_SEARCH: begin
				step = !done_q;
				if (found || (done_q && !cmp_s1)) begin
					state_d = BK_SEND_A;
				end
			end
			BK_SEND_A: begin
				if (slot_free) begin
					send_a  = 1'b1;
					state_d = BK_SEND_B;
				end
			end
			BK_SEND_B: begin
				if (slot_free) begin
					send_b  = 1'b1;
					pop     = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// pair walk: j runs over B entries, i over A entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			done_q <= 1'b0;
			cmp_s1 <= 1'b0;
			stub_q <= 1'b0;
		end else begin
			cmp_s1 <= step;
			if (start) begin
				i_q    <= '0;
				j_q    <= '0;
				done_q <= 1'b0;
				stub_q <= 1'b0;
			end else begin
				if (step) begin
					if (CNT_W'(j_q) + 1'b1 == head.b.stored) begin
						j_q <= '0;
						if (CNT_W'(i_q) + 1'b1 == head.a.stored) begin
							done_q <= 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				if (found && state_q == BK_SEARCH) begin
					stub_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (send_a || send_b) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (send_a) begin
			result_q <= make_result(head.a, 1'b0, stub_q);
		end else if (send_b) begin
			result_q <= make_result(head.b, 1'b1, stub_q);
		end
	end

endmodule

// File: design/strip_cluster_stub_finder_unit.sv
// ----------------------------------------------------------------------------
// strip_cluster_stub_finder_unit: cluster and stub finder for two sensors
// Clusters hit strips of two stacked strip sensors, counts them per sensor
// and flags stubs from accepted cluster pairs within a position window.
// ----------------------------------------------------------------------------
// Strips enter at one beat per cycle unless stalled: the front clusters both
// sensors on the fly and, on the last strip, hands the event's counts to a
// two-entry event queue, with accepted positions kept in one position RAM
// bank per queue entry. The back searches up to nA*nB A/B position pairs
// one pair per cycle from those RAMs (nA, nB: stored accepted clusters, at
// most MAX_CLUSTERS each), then sends two result beats, A first. The front
// keeps taking strips of the next event meanwhile, and stalls only while two
// finished events are waiting in the queue.
// ----------------------------------------------------------------------------
module strip_cluster_stub_finder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              strip_valid,
	output logic                              strip_stall,
	input  scsf_pkg::strip_t                  strip,
	output logic                              result_valid,
	input  logic                              result_stall,
	output scsf_pkg::result_t                 result,
	input  logic                              cfg_write_en,
	input  logic [scsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import scsf_pkg::*;

	logic [THR_W-1:0]      hit_threshold_q;
	logic [MAXW_W-1:0]     max_accepted_width_q;
	logic [WIN_W-1:0]      match_window_q;

	logic                  push;
	logic                  pop;
	event_desc_t           push_desc;
	event_desc_t           head;
	evq_status_t           evq_status;
	pos_wr_t               pos_wr_a;
	pos_wr_t               pos_wr_b;
	logic [POS_ADDR_W-1:0] rd_addr_a;
	logic [POS_ADDR_W-1:0] rd_addr_b;
	logic [IDX_W-1:0]      rd_data_a;
	logic [IDX_W-1:0]      rd_data_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_threshold_q      <= HIT_THRESHOLD_RST;
			max_accepted_width_q <= MAX_ACCEPTED_WIDTH_RST;
			match_window_q       <= MATCH_WINDOW_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_HIT_THRESHOLD:      hit_threshold_q      <= cfg_data[THR_W-1:0];
				CFG_MAX_ACCEPTED_WIDTH: max_accepted_width_q <= cfg_data[MAXW_W-1:0];
				CFG_MATCH_WINDOW:       match_window_q       <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: intake and clustering
	scsf_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.strip_valid        (strip_valid),
		.strip_stall        (strip_stall),
		.strip              (strip),
		.hit_threshold      (hit_threshold_q),
		.max_accepted_width (max_accepted_width_q),
		.evq_status         (evq_status),
		.push               (push),
		.push_desc          (push_desc),
		.pos_wr_a           (pos_wr_a),
		.pos_wr_b           (pos_wr_b)
	);

	// finished events waiting for the back
	scsf_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.status    (evq_status),
		.head      (head)
	);

	// accepted cluster positions, one bank per queue entry
	scsf_ram #(
		.WIDTH (IDX_W),
		.DEPTH (POS_DEPTH)
	) u_pos_a (
		.clk     (clk),
		.wr_en   (pos_wr_a.en),
		.wr_addr (pos_wr_a.addr),
		.wr_data (pos_wr_a.data),
		.rd_addr (rd_addr_a),
		.rd_data (rd_data_a)
	);

	scsf_ram #(
		.WIDTH (IDX_W),
		.DEPTH (POS_DEPTH)
	) u_pos_b (
		.clk     (clk),
		.wr_en   (pos_wr_b.en),
		.wr_addr (pos_wr_b.addr),
		.wr_data (pos_wr_b.data),
		.rd_addr (rd_addr_b),
		.rd_data (rd_data_b)
	);

	// back: stub search and results
	scsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.match_window (match_window_q),
		.evq_status   (evq_status),
		.head         (head),
		.pop          (pop),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.rd_data_a    (rd_data_a),
		.rd_data_b    (rd_data_b),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
